// ===== sv/ctpl_pkg.sv =====
package ctpl_pkg;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int COEF_WIDTH     = 24;
  localparam int COEF_FRAC_BITS = 20;
  localparam int NUM_REGS       = 3;
  localparam int CFG_IDX_WIDTH  = 2;

  localparam int PROD_WIDTH = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_WIDTH  = PROD_WIDTH + 2;
  localparam int RND_WIDTH  = ACC_WIDTH + 1 - COEF_FRAC_BITS;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;
  typedef logic signed [PROD_WIDTH-1:0]   prod_t;
  typedef logic signed [ACC_WIDTH-1:0]    acc_t;
  typedef logic signed [RND_WIDTH-1:0]    rnd_t;
  typedef logic [CFG_IDX_WIDTH-1:0]       cfg_idx_t;

  localparam cfg_idx_t REG_FEEDBACK_ONE = cfg_idx_t'(0);
  localparam cfg_idx_t REG_FEEDBACK_TWO = cfg_idx_t'(1);
  localparam cfg_idx_t REG_INPUT_GAIN   = cfg_idx_t'(2);

  localparam coef_t FEEDBACK_ONE_RESET = coef_t'(1576640);
  localparam coef_t FEEDBACK_TWO_RESET = coef_t'(-593070);
  localparam coef_t INPUT_GAIN_RESET   = coef_t'(65012);

  // Multiply-accumulate steps within one section.
  typedef enum logic [1:0] {
    STEP_FB_ONE = 2'd0,
    STEP_FB_TWO = 2'd1,
    STEP_INPUT  = 2'd2,
    STEP_DRAIN  = 2'd3
  } step_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_SAT
  } state_t;

  localparam acc_t ROUND_OFFSET = acc_t'(1) <<< (COEF_FRAC_BITS - 1);
  localparam rnd_t SAMPLE_MAX   = rnd_t'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam rnd_t SAMPLE_MIN   = rnd_t'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

endpackage

// ===== sv/ctpl_stream_if.sv =====
interface ctpl_in_if;
  logic                 valid;
  logic                 ready;
  ctpl_pkg::sample_t    sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface ctpl_out_if;
  logic                 valid;
  logic                 ready;
  ctpl_pkg::sample_t    sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== sv/cascaded_two_pole_lowpass_unit.sv =====
// Two identical two-pole low-pass sections in cascade, y = a*y1 + b*y2 + c*x per section,
// sharing the Q4.20 coefficients a, b and c written through the cfg_ port (indexes 0, 1, 2).
// Samples are signed Q1.15; each section output is rounded (ties upward) and saturated
// before it is stored and passed on. A single 24 x 16 multiplier does all six products in
// multiply-accumulate steps and a rounding step per section; a new request is accepted only
// after both sections are done. The finished sample is held in an output register, so the
// next request may be accepted while it waits to be taken. The filter history is kept on a
// coefficient write; the user must write between samples for it to take effect from the next sample (not enforced).
module cascaded_two_pole_lowpass_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  ctpl_in_if.sink                    in_s,
  ctpl_out_if.source                 out_s,
  input  logic                       cfg_we,
  input  ctpl_pkg::cfg_idx_t         cfg_index,
  input  ctpl_pkg::coef_t            cfg_wdata
);

  ctpl_pkg::state_t  state_r, state_nxt;
  ctpl_pkg::step_t   step_r;
  logic              sec_r;

  ctpl_pkg::coef_t   coef_a_r, coef_b_r, coef_c_r;
  ctpl_pkg::sample_t x_r;
  ctpl_pkg::sample_t prev_one_r [2];
  ctpl_pkg::sample_t prev_two_r [2];
  ctpl_pkg::prod_t   prod_r;
  ctpl_pkg::acc_t    acc_r;
  ctpl_pkg::sample_t out_sample_r;
  logic              out_valid_r;

  ctpl_pkg::coef_t   coef_sel;
  ctpl_pkg::sample_t samp_sel;
  ctpl_pkg::prod_t   mul_w;
  ctpl_pkg::acc_t    sum_w;
  ctpl_pkg::rnd_t    rnd_w;
  ctpl_pkg::sample_t sat_w;

  logic in_accept;
  logic sat_go;
  logic out_load;

  assign in_accept = in_s.valid && in_s.ready;

  // Operand selection for the shared multiplier.
  always_comb begin
    case (step_r)
      ctpl_pkg::STEP_FB_ONE: begin
        coef_sel = coef_a_r;
        samp_sel = prev_one_r[sec_r];
      end
      ctpl_pkg::STEP_FB_TWO: begin
        coef_sel = coef_b_r;
        samp_sel = prev_two_r[sec_r];
      end
      ctpl_pkg::STEP_INPUT: begin
        coef_sel = coef_c_r;
        samp_sel = x_r;
      end
      default: begin
        coef_sel = coef_c_r;
        samp_sel = x_r;
      end
    endcase
  end

  assign mul_w = ctpl_pkg::prod_t'(coef_sel) * ctpl_pkg::prod_t'(samp_sel);

  // The accumulator has headroom for the rounding offset, so one add suffices.
  assign sum_w = acc_r + ctpl_pkg::ROUND_OFFSET;
  assign rnd_w = ctpl_pkg::rnd_t'(sum_w >>> ctpl_pkg::COEF_FRAC_BITS);

  always_comb begin
    if (rnd_w > ctpl_pkg::SAMPLE_MAX) begin
      sat_w = ctpl_pkg::sample_t'(ctpl_pkg::SAMPLE_MAX);
    end else if (rnd_w < ctpl_pkg::SAMPLE_MIN) begin
      sat_w = ctpl_pkg::sample_t'(ctpl_pkg::SAMPLE_MIN);
    end else begin
      sat_w = ctpl_pkg::sample_t'(rnd_w);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ctpl_pkg::ST_IDLE: begin
        if (in_s.valid) state_nxt = ctpl_pkg::ST_MAC;
      end
      ctpl_pkg::ST_MAC: begin
        if (step_r == ctpl_pkg::STEP_DRAIN) state_nxt = ctpl_pkg::ST_SAT;
      end
      ctpl_pkg::ST_SAT: begin
        if (sat_go) state_nxt = sec_r ? ctpl_pkg::ST_IDLE : ctpl_pkg::ST_MAC;
      end
      default: state_nxt = ctpl_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_s.ready = 1'b0;
    sat_go     = 1'b0;
    case (state_r)
      ctpl_pkg::ST_IDLE: in_s.ready = 1'b1;
      ctpl_pkg::ST_SAT:  sat_go = !sec_r || !out_valid_r || out_s.ready;
      default: begin
        in_s.ready = 1'b0;
        sat_go     = 1'b0;
      end
    endcase
  end

  assign out_load = sat_go && sec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ctpl_pkg::ST_IDLE;
      step_r        <= ctpl_pkg::STEP_FB_ONE;
      sec_r         <= 1'b0;
      out_valid_r   <= 1'b0;
      coef_a_r      <= ctpl_pkg::FEEDBACK_ONE_RESET;
      coef_b_r      <= ctpl_pkg::FEEDBACK_TWO_RESET;
      coef_c_r      <= ctpl_pkg::INPUT_GAIN_RESET;
      prev_one_r[0] <= '0;
      prev_one_r[1] <= '0;
      prev_two_r[0] <= '0;
      prev_two_r[1] <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          ctpl_pkg::REG_FEEDBACK_ONE: coef_a_r <= cfg_wdata;
          ctpl_pkg::REG_FEEDBACK_TWO: coef_b_r <= cfg_wdata;
          ctpl_pkg::REG_INPUT_GAIN:   coef_c_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (state_r == ctpl_pkg::ST_MAC) begin
        step_r <= ctpl_pkg::step_t'(step_r + 2'd1);
      end

      if (in_accept) begin
        sec_r <= 1'b0;
      end else if (sat_go) begin
        sec_r                <= !sec_r;
        prev_one_r[sec_r]    <= sat_w;
        prev_two_r[sec_r]    <= prev_one_r[sec_r];
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_s.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      x_r <= in_s.sample_in;
    end else if (sat_go && !sec_r) begin
      x_r <= sat_w;
    end

    if (state_r == ctpl_pkg::ST_MAC) begin
      prod_r <= mul_w;
      case (step_r)
        ctpl_pkg::STEP_FB_ONE: acc_r <= acc_r;
        ctpl_pkg::STEP_FB_TWO: acc_r <= ctpl_pkg::acc_t'(prod_r);
        default:               acc_r <= acc_r + ctpl_pkg::acc_t'(prod_r);
      endcase
    end

    if (out_load) begin
      out_sample_r <= sat_w;
    end
  end

  assign out_s.valid      = out_valid_r;
  assign out_s.sample_out = out_sample_r;

`ifndef NO_ASSERTIONS
  a_accept_starts_mac: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == ctpl_pkg::ST_MAC && step_r == ctpl_pkg::STEP_FB_ONE && !sec_r)
    else $error("accepted request did not start the first section");

  a_sat_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ctpl_pkg::ST_SAT) |->
      $past(state_r) == ctpl_pkg::ST_MAC && $past(step_r) == ctpl_pkg::STEP_DRAIN)
    else $error("rounding entered before the accumulation finished");

  a_out_from_second_section: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ctpl_pkg::ST_SAT && $past(sec_r))
    else $error("result raised other than at the end of the second section");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ctpl_pkg::ST_IDLE |-> !in_s.ready)
    else $error("input ready while a sample is in progress");
`endif

endmodule
